[rtl/wnns_pkg.sv]
package wnns_pkg;

    // Sizing
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 20;
    localparam int POS_W      = 10;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int IDX_W      = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 3;
    localparam int CHAIN_W    = 11;
    localparam int WIN_W      = 10;
    localparam int SPAN_W     = 6;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;

    // Distance limit: 999 units with 8 fractional bits
    localparam int LIMIT_RAW = 999 * 256;
    localparam int LIM_W     = $clog2(LIMIT_RAW);
    localparam int SQ_W      = 2 * LIM_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int CMP_W     = (COORD_BITS + 1 > LIM_W) ? COORD_BITS + 1 : LIM_W;
    localparam logic [SUM_W-1:0] LIMIT_SQ =
        SUM_W'(longint'(LIMIT_RAW) * longint'(LIMIT_RAW));

    // Drain after the last candidate issue, until its best-so-far update has landed
    localparam int DRAIN_CYC = 3;
    localparam int DRAIN_W   = $clog2(DRAIN_CYC);

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHAIN  = 2'd0,
        CFG_WINDOW = 2'd1,
        CFG_SPAN   = 2'd2
    } t_cfg_idx;

    typedef logic signed [IDX_W-1:0] t_sidx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

    typedef struct packed {
        logic                         opcode;
        logic [POS_W-1:0]             position;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } t_in;

    typedef struct packed {
        logic [POS_W-1:0] nearest_pos;
        logic             nearest_found;
        logic [POS_W-1:0] reverse_pos;
        logic             reverse_found;
        logic [POS_W-1:0] forward_pos;
        logic             forward_found;
        logic [POS_W-1:0] backward_pos;
        logic             backward_found;
    } t_out;

    typedef struct packed {
        logic [CHAIN_W-1:0] chain_length;
        logic [WIN_W-1:0]   search_window;
        logic [SPAN_W-1:0]  exclude_span;
    } t_cfg;

    // Point store access
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_point            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Candidate tag entering the distance unit
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] pos;
    } t_dist_tag;

    // Distance unit result
    typedef struct packed {
        logic                       vld;
        logic                       ok;
        logic [ADDR_W-1:0]          pos;
        logic [2:0][SQ_W-1:0]       sq;
    } t_dist_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QLOAD,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_END,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        P_NEAR,
        P_REV,
        P_FWD,
        P_BWD
    } t_pass;

endpackage

[rtl/windowed_nearest_neighbor_search_core.sv]
// Load: written to the store at acceptance, produces no transaction on the output.
// Query: a query-point load, then 4 passes (nearest, reverse, forward, backward); a pass
//   sets up its range, scans a non-empty range with one store read per cycle through
//   the distance pipeline, drains it, and ends by filling its result slot.
// One query in flight; loads are taken while a result waits in the output register.
// Reset (synchronous, active low) restores the registers to 0, 32, 3; store is not cleared.
module windowed_nearest_neighbor_search_core import wnns_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out      r_out_data;

    logic      out_free;
    logic      res_vld;
    t_out      res;
    t_mem_req  mem_req;
    t_point    rd_data;
    t_dist_tag tag;
    t_point    qpt;
    t_dist_res dist_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chain_length  <= CHAIN_W'(0);
            r_cfg.search_window <= WIN_W'(32);
            r_cfg.exclude_span  <= SPAN_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHAIN:  r_cfg.chain_length  <= i_cfg_data[CHAIN_W-1:0];
                CFG_WINDOW: r_cfg.search_window <= i_cfg_data[WIN_W-1:0];
                CFG_SPAN:   r_cfg.exclude_span  <= i_cfg_data[SPAN_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_vld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_vld) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    wnns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .o_mem      (mem_req),
        .i_rd_data  (rd_data),
        .o_tag      (tag),
        .o_q        (qpt),
        .i_dist     (dist_res)
    );

    wnns_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    wnns_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag),
        .i_q     (qpt),
        .i_p     (rd_data),
        .o_res   (dist_res)
    );

endmodule

[rtl/wnns_store.sv]
module wnns_store import wnns_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_point   o_rd_data
);

    t_point r_mem [MAX_POINTS];
    t_point r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/wnns_dist.sv]
module wnns_dist import wnns_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dist_tag i_tag,
    input  t_point    i_q,
    input  t_point    i_p,
    output t_dist_res o_res
);

    logic signed [COORD_BITS-1:0] qa [3];
    logic signed [COORD_BITS-1:0] pa [3];
    logic signed [COORD_BITS:0]   diff [3];
    logic [COORD_BITS:0]          mag [3];
    logic [2:0]                   over;

    logic [LIM_W-1:0]             r_abs [3];
    logic                         r_over;
    t_dist_tag                    r_tag1;
    t_dist_res                    r_res;

    assign qa[0] = i_q.x;
    assign qa[1] = i_q.y;
    assign qa[2] = i_q.z;
    assign pa[0] = i_p.x;
    assign pa[1] = i_p.y;
    assign pa[2] = i_p.z;

    // Stage 1: per-axis absolute difference and limit check
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = (COORD_BITS+1)'(qa[k]) - (COORD_BITS+1)'(pa[k]);
            mag[k]  = diff[k][COORD_BITS] ? (COORD_BITS+1)'(-diff[k])
                                          : (COORD_BITS+1)'(diff[k]);
            over[k] = CMP_W'(mag[k]) >= CMP_W'(LIMIT_RAW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.vld <= 1'b0;
        end else begin
            r_tag1.vld <= i_tag.vld;
        end
        r_tag1.pos <= i_tag.pos;
        r_over     <= |over;
        for (int k = 0; k < 3; k++) begin
            r_abs[k] <= LIM_W'(mag[k]);
        end
    end

    // Stage 2: squares, one lane per axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.vld <= 1'b0;
        end else begin
            r_res.vld <= r_tag1.vld;
        end
        r_res.pos <= r_tag1.pos;
        r_res.ok  <= !r_over;
        for (int k = 0; k < 3; k++) begin
            r_res.sq[k] <= SQ_W'(r_abs[k]) * SQ_W'(r_abs[k]);
        end
    end

    assign o_res = r_res;

endmodule

[rtl/wnns_ctrl.sv]
module wnns_ctrl import wnns_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in       i_in_data,
    input  t_cfg      i_cfg,
    input  logic      i_out_free,
    output logic      o_res_vld,
    output t_out      o_res,
    output t_mem_req  o_mem,
    input  t_point    i_rd_data,
    output t_dist_tag o_tag,
    output t_point    o_q,
    input  t_dist_res i_dist
);

    t_state             r_state, n_state;
    t_pass              r_pass, n_pass;
    logic [POS_W-1:0]   r_pos;
    logic               r_q_in;
    t_point             r_q;
    t_sidx              r_cur, r_to, r_ex_lo, r_ex_hi;
    logic               r_down;
    logic               r_excl;
    logic [DRAIN_W-1:0] r_drain;
    t_dist_tag          r_tag;
    logic               r_found;
    logic [SUM_W-1:0]   r_best;
    logic [ADDR_W-1:0]  r_bpos;
    t_out               r_res;

    logic               in_acc;
    logic               q_acc;
    t_sidx              s_pos, s_win, s_span, s_chain, s_max, s_len, s_last;
    t_sidx              s_qpos;
    t_sidx              f_from, f_to;
    logic               f_down, f_excl, f_force_empty, f_empty;
    logic               skip;
    logic               last;
    logic [SUM_W-1:0]   dsum;
    logic               win;

    function automatic t_sidx f_smax(input t_sidx a, input t_sidx b);
        f_smax = (a > b) ? a : b;
    endfunction

    function automatic t_sidx f_smin(input t_sidx a, input t_sidx b);
        f_smin = (a < b) ? a : b;
    endfunction

    assign in_acc = (r_state == S_IDLE) && i_in_valid;
    assign q_acc  = in_acc && (i_in_data.opcode == OP_QUERY);
    assign s_qpos = t_sidx'(i_in_data.position);

    // Chain bounds and query position as signed indexes
    always_comb begin
        s_pos   = t_sidx'(r_pos);
        s_win   = t_sidx'(i_cfg.search_window);
        s_span  = t_sidx'(i_cfg.exclude_span);
        s_chain = t_sidx'(i_cfg.chain_length);
        s_max   = t_sidx'(MAX_POINTS);
        s_len   = (s_chain > s_max) ? s_max : s_chain;
        s_last  = s_len - t_sidx'(1);
    end

    // Scan range of the current pass
    always_comb begin
        f_from        = t_sidx'(0);
        f_to          = t_sidx'(0);
        f_down        = 1'b0;
        f_excl        = 1'b0;
        f_force_empty = 1'b0;
        case (r_pass)
            P_NEAR: begin
                f_from = f_smax(t_sidx'(0), s_pos - s_win);
                f_to   = f_smin(s_last, s_pos + s_win);
                f_excl = 1'b1;
            end
            P_REV: begin
                f_excl        = 1'b1;
                f_force_empty = !r_res.nearest_found;
                if (r_res.nearest_pos > r_pos) begin
                    f_from = f_smax(t_sidx'(0), s_pos - s_win);
                    f_to   = f_smin(s_pos - t_sidx'(1), s_last);
                end else begin
                    f_from = s_pos + t_sidx'(1);
                    f_to   = f_smin(s_last, s_pos + s_win);
                end
            end
            P_FWD: begin
                f_from = s_pos + s_span;
                f_to   = s_last;
            end
            P_BWD: begin
                f_from = f_smin(s_pos - s_span, s_last);
                f_to   = t_sidx'(0);
                f_down = 1'b1;
            end
            default: begin
                f_force_empty = 1'b1;
            end
        endcase
        f_empty = f_force_empty || (f_down ? (f_from < f_to) : (f_from > f_to));
    end

    assign skip = r_excl && (r_cur >= r_ex_lo) && (r_cur <= r_ex_hi);
    assign last = (r_cur == r_to);

    // Best-so-far compare on the distance unit output
    assign dsum = SUM_W'(i_dist.sq[0]) + SUM_W'(i_dist.sq[1]) + SUM_W'(i_dist.sq[2]);
    assign win  = i_dist.vld && i_dist.ok && (dsum < r_best);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= P_NEAR;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_in_stall = (r_state != S_IDLE);
        o_res_vld  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (q_acc) begin
                    n_state = S_QLOAD;
                    n_pass  = P_NEAR;
                end
            end
            S_QLOAD: begin
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = f_empty ? S_END : S_SCAN;
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == DRAIN_W'(DRAIN_CYC - 1)) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                unique case (r_pass)
                    P_NEAR:  n_pass = P_REV;
                    P_REV:   n_pass = P_FWD;
                    P_FWD:   n_pass = P_BWD;
                    P_BWD:   n_pass = P_BWD;
                    default: n_pass = P_NEAR;
                endcase
                n_state = (r_pass == P_BWD) ? S_DONE : S_SETUP;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Store access: loads write at accept; reads follow the scan index, else the input position
    always_comb begin
        o_mem.we    = in_acc && (i_in_data.opcode == OP_LOAD) &&
                      (s_qpos < t_sidx'(MAX_POINTS));
        o_mem.waddr = ADDR_W'(i_in_data.position);
        o_mem.wdata = {i_in_data.coord_x, i_in_data.coord_y, i_in_data.coord_z};
        o_mem.raddr = (r_state == S_SCAN) ? r_cur[ADDR_W-1:0]
                                          : ADDR_W'(i_in_data.position);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
            r_found   <= 1'b0;
            r_drain   <= '0;
            r_res     <= '0;
        end else begin
            // tag lines up with the registered store read
            r_tag.vld <= (r_state == S_SCAN) && !skip;

            if (r_state == S_DRAIN) begin
                r_drain <= r_drain + DRAIN_W'(1);
            end else begin
                r_drain <= '0;
            end

            if (r_state == S_SETUP) begin
                r_found <= 1'b0;
            end else if (win) begin
                r_found <= 1'b1;
            end

            // one result slot per pass
            if (q_acc) begin
                r_res <= '0;
            end else if (r_state == S_END) begin
                case (r_pass)
                    P_NEAR: begin
                        r_res.nearest_pos   <= POS_W'(r_bpos);
                        r_res.nearest_found <= r_found;
                    end
                    P_REV: begin
                        r_res.reverse_pos   <= POS_W'(r_bpos);
                        r_res.reverse_found <= r_found;
                    end
                    P_FWD: begin
                        r_res.forward_pos   <= POS_W'(r_bpos);
                        r_res.forward_found <= r_found;
                    end
                    P_BWD: begin
                        r_res.backward_pos   <= POS_W'(r_bpos);
                        r_res.backward_found <= r_found;
                    end
                    default: begin
                        r_res <= r_res;
                    end
                endcase
            end
        end
        // candidate index travels with its valid bit
        r_tag.pos <= r_cur[ADDR_W-1:0];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (q_acc) begin
            r_pos  <= i_in_data.position;
            r_q_in <= s_qpos < t_sidx'(MAX_POINTS);
        end

        // query point; outside the store it sits at the origin
        if (r_state == S_QLOAD) begin
            r_q <= r_q_in ? i_rd_data : '0;
        end

        if (r_state == S_SETUP) begin
            r_cur   <= f_from;
            r_to    <= f_to;
            r_down  <= f_down;
            r_excl  <= f_excl;
            r_ex_lo <= s_pos - s_span;
            r_ex_hi <= s_pos + s_span;
        end else if (r_state == S_SCAN) begin
            r_cur <= r_down ? r_cur - t_sidx'(1) : r_cur + t_sidx'(1);
        end

        if (r_state == S_SETUP) begin
            r_best <= LIMIT_SQ;
            r_bpos <= '0;
        end else if (win) begin
            r_best <= dsum;
            r_bpos <= i_dist.pos;
        end
    end

    assign o_tag = r_tag;
    assign o_q   = r_q;
    assign o_res = r_res;

    // Candidates always stay inside the chain
    a_scan_in_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cur >= t_sidx'(0) && r_cur <= s_last))
        else $error("scan index outside chain");

    // Reverse result is only possible with a nearest result
    a_rev_needs_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.reverse_found |-> r_res.nearest_found)
        else $error("reverse found without nearest");

    // A found candidate is always inside the distance limit
    a_best_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_best < LIMIT_SQ))
        else $error("best distance beyond limit");

    // Backward pass is the last one
    a_done_after_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && r_pass == P_BWD) |=> (r_state == S_DONE))
        else $error("sequencer skipped result");

    // Distance pipeline is drained whenever the block is idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_dist.vld)
        else $error("distance result while idle");

endmodule

[tb/tb_windowed_nearest_neighbor_search_core.sv]
`timescale 1ns / 1ps

module tb_windowed_nearest_neighbor_search_core import wnns_pkg::*;;

    localparam int WAIT_MAX       = 13;
    localparam int SETTLE_CYC     = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 16;
    localparam int FULL_LEN       = 64;
    localparam int LIMIT_UNITS    = 999 * 256;
    localparam int MSG_CAP        = 40;

    typedef enum bit {
        STEP_ITEM,
        STEP_REG
    } t_step_kind;

    // One row of the directed plan
    typedef struct {
        t_step_kind kind;
        t_cfg_idx   idx;
        int         val;
        t_in        item;
        bit         typed;
        t_out       want;
    } t_step;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in                  in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_out                 out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    windowed_nearest_neighbor_search_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Shadow copy of the point store and registers
    t_point point_mem [MAX_POINTS];
    bit     written [MAX_POINTS];
    int     written_list [$];
    int     chain_len  = 0;
    int     win_half   = 32;
    int     excl_span  = 3;

    t_out   pending_neighbors [$];
    t_step  plan [$];
    int     err_count   = 0;
    int     send_calm   = 0;
    int     recv_calm   = 0;
    int     idle_cycles = 0;
    int     center [3];
    int     spread = 256;

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MSG_CAP)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Wait before the next transaction; occasional runs of back-to-back traffic
    function automatic int draw_wait(input bit recv);
        int calm;
        calm = recv ? recv_calm : send_calm;
        if (calm > 0)
            calm--;
        else if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(8, 30);
        if (recv)
            recv_calm = calm;
        else
            send_calm = calm;
        return (calm > 0) ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    // Squared distance in d; returns 0 if any axis is at or past the limit
    function automatic bit sq_dist(input t_point a, input t_point b, output longint d);
        longint ca [3];
        longint cb [3];
        longint diff;
        ca[0] = $signed(a.x);
        ca[1] = $signed(a.y);
        ca[2] = $signed(a.z);
        cb[0] = $signed(b.x);
        cb[1] = $signed(b.y);
        cb[2] = $signed(b.z);
        d = 0;
        for (int k = 0; k < 3; k++) begin
            diff = ca[k] - cb[k];
            if (diff < 0)
                diff = -diff;
            if (diff >= LIMIT_UNITS)
                return 1'b0;
            d += diff * diff;
        end
        return 1'b1;
    endfunction

    // Closest point over [from..to] in direction dir; strict less keeps first hit
    function automatic void closest_in_span(input t_point q, input int qpos, input int from,
                                            input int to, input int dir, input bit excl,
                                            output bit found, output int pos);
        longint best;
        longint d;
        int     c;
        bit     skip;
        bit     ok;
        best  = longint'(LIMIT_UNITS) * longint'(LIMIT_UNITS);
        found = 1'b0;
        pos   = 0;
        if ((dir > 0 && from > to) || (dir < 0 && from < to))
            return;
        c = from;
        while (1) begin
            skip = excl && (c + excl_span >= qpos) && (c <= qpos + excl_span);
            if (!skip && c >= 0 && c < MAX_POINTS) begin
                ok = sq_dist(q, point_mem[c], d);
                if (ok && d < best) begin
                    best  = d;
                    found = 1'b1;
                    pos   = c;
                end
            end
            if (c == to)
                break;
            c += dir;
        end
    endfunction

    // Four neighbor searches around position p
    function automatic t_out neighbors_of(input int p);
        t_point q;
        t_out   r;
        int     eff_len, lo, hi, np, rp, fp, bp;
        bit     nf, rf, ff, bf;
        eff_len = (chain_len > MAX_POINTS) ? MAX_POINTS : chain_len;
        q  = point_mem[p];
        lo = (p - win_half < 0) ? 0 : p - win_half;
        hi = (p + win_half > eff_len - 1) ? eff_len - 1 : p + win_half;
        closest_in_span(q, p, lo, hi, 1, 1'b1, nf, np);
        rf = 1'b0;
        rp = 0;
        if (nf) begin
            // reverse side is opposite the nearest hit
            if (np > p) begin
                hi = p - 1;
                if (hi > eff_len - 1)
                    hi = eff_len - 1;
            end else begin
                lo = p + 1;
            end
            closest_in_span(q, p, lo, hi, 1, 1'b1, rf, rp);
        end
        closest_in_span(q, p, p + excl_span, eff_len - 1, 1, 1'b0, ff, fp);
        lo = p - excl_span;
        if (lo > eff_len - 1)
            lo = eff_len - 1;
        closest_in_span(q, p, lo, 0, -1, 1'b0, bf, bp);
        r.nearest_pos    = np[POS_W-1:0];
        r.nearest_found  = nf;
        r.reverse_pos    = rp[POS_W-1:0];
        r.reverse_found  = rf;
        r.forward_pos    = fp[POS_W-1:0];
        r.forward_found  = ff;
        r.backward_pos   = bp[POS_W-1:0];
        r.backward_found = bf;
        return r;
    endfunction

    // Coordinates clustered around a phase center, with limit probes and full-range noise
    function automatic logic signed [COORD_BITS-1:0] gen_coord(input int axis);
        int v;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            v = $urandom;
            return v[COORD_BITS-1:0];
        end
        if (r == 1)
            v = center[axis] + ($urandom_range(0, 1) ? LIMIT_UNITS : -LIMIT_UNITS)
                + int'($urandom_range(0, 2)) - 1;
        else
            v = center[axis] + (int'($urandom_range(0, 6)) - 3) * spread;
        if (v > 524287)
            v = 524287;
        if (v < -524288)
            v = -524288;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_in make_load(input int pos);
        t_in it;
        it.opcode   = OP_LOAD;
        it.position = pos[POS_W-1:0];
        it.coord_x  = gen_coord(0);
        it.coord_y  = gen_coord(1);
        it.coord_z  = gen_coord(2);
        return it;
    endfunction

    function automatic t_in make_query(input int pos);
        t_in it;
        it          = make_load(pos);
        it.opcode   = OP_QUERY;
        return it;
    endfunction

    // Directed plan rows
    function automatic void add_load(input int pos, input int x, input int y, input int z);
        t_step s;
        s.kind          = STEP_ITEM;
        s.item.opcode   = OP_LOAD;
        s.item.position = pos[POS_W-1:0];
        s.item.coord_x  = x[COORD_BITS-1:0];
        s.item.coord_y  = y[COORD_BITS-1:0];
        s.item.coord_z  = z[COORD_BITS-1:0];
        s.typed         = 1'b0;
        s.want          = '0;
        plan.insert(plan.size(), s);
    endfunction

    function automatic void add_query(input int pos, input bit none_found);
        t_step s;
        s.kind          = STEP_ITEM;
        s.item          = '0;
        s.item.opcode   = OP_QUERY;
        s.item.position = pos[POS_W-1:0];
        s.typed         = none_found;
        s.want          = '0;
        plan.insert(plan.size(), s);
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input int val);
        t_step s;
        s.kind = STEP_REG;
        s.idx  = idx;
        s.val  = val;
        plan.insert(plan.size(), s);
    endfunction

    // Send one transaction and record its expected neighbors at acceptance
    task automatic push_item(input t_in it, input bit typed, input t_out want);
        int gap;
        int p;
        gap = draw_wait(1'b0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        p = it.position;
        if (it.opcode == OP_LOAD) begin
            point_mem[p].x = it.coord_x;
            point_mem[p].y = it.coord_y;
            point_mem[p].z = it.coord_z;
            if (!written[p]) begin
                written[p] = 1'b1;
                written_list.insert(written_list.size(), p);
            end
        end else begin
            pending_neighbors.insert(pending_neighbors.size(),
                                     typed ? want : neighbors_of(p));
        end
    endtask

    // Hold the sender until every result is back and the block has settled
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_CHAIN:  chain_len = val & 'h7FF;
            CFG_WINDOW: win_half  = val & 'h3FF;
            CFG_SPAN:   excl_span = val & 'h3F;
            default: ;
        endcase
    endtask

    // Result checker
    always @(posedge clk) begin : result_check
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_neighbors.size() == 0) begin
                report_mismatch("result transaction with no query pending");
            end else begin
                want = pending_neighbors.pop_front();
                check_field("nearest_pos", out_data.nearest_pos, want.nearest_pos);
                check_field("nearest_found", out_data.nearest_found, want.nearest_found);
                check_field("reverse_pos", out_data.reverse_pos, want.reverse_pos);
                check_field("reverse_found", out_data.reverse_found, want.reverse_found);
                check_field("forward_pos", out_data.forward_pos, want.forward_pos);
                check_field("forward_found", out_data.forward_found, want.forward_found);
                check_field("backward_pos", out_data.backward_pos, want.backward_pos);
                check_field("backward_found", out_data.backward_found, want.backward_found);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_windowed_nearest_neighbor_search_core: FAIL");
                $finish;
            end
        end
    end

    // Receiver back-pressure
    initial begin
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            n = draw_wait(1'b1);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Stimulus
    initial begin
        int len, win, sp, pos, hi_load;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        center    = '{0, 0, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty chain, distance limit edges, ties, window and span extremes,
        // queries past the chain end
        add_load(0, 0, 0, 0);
        add_query(0, 1'b1);
        add_reg(CFG_CHAIN, 8);
        add_load(1, 524287, 524287, 524287);
        add_load(2, -524288, -524288, -524288);
        add_load(3, LIMIT_UNITS - 1, 0, 0);
        add_load(4, LIMIT_UNITS, 0, 0);
        add_load(5, 256, 256, 256);
        add_load(6, 256, 256, 256);
        add_load(7, -256, 0, 0);
        add_query(1, 1'b1);
        add_query(2, 1'b1);
        add_query(0, 1'b0);
        add_query(5, 1'b0);
        add_reg(CFG_SPAN, 0);
        add_query(6, 1'b0);
        add_reg(CFG_WINDOW, 1);
        add_query(3, 1'b0);
        add_reg(CFG_SPAN, 63);
        add_reg(CFG_WINDOW, 1023);
        add_query(7, 1'b0);
        add_reg(CFG_CHAIN, 4);
        add_query(6, 1'b0);
        add_load(1023, -1, 1, 0);
        add_query(1023, 1'b0);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                quiesce();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                push_item(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        // Random phases, each with its own register setting and point cluster
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0)
                len = 0;
            else if (ph == 4 || ph == 9)
                len = FULL_LEN;
            else
                len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? FULL_LEN : 40);
            case ($urandom_range(0, 3))
                0:       win = 1;
                1:       win = 1023;
                default: win = $urandom_range(2, 48);
            endcase
            case ($urandom_range(0, 3))
                0:       sp = 0;
                1:       sp = 63;
                default: sp = $urandom_range(0, 8);
            endcase
            if (ph == 4) begin
                win = 1023;
                sp  = 0;
            end
            if (ph == 9)
                sp = 63;
            case ($urandom_range(0, 3))
                0:       spread = 1;
                1:       spread = 256;
                2:       spread = 4096;
                default: spread = 60000;
            endcase
            for (int k = 0; k < 3; k++)
                center[k] = int'($urandom_range(0, 400000)) - 200000;

            quiesce();
            write_reg(CFG_CHAIN, len);
            write_reg(CFG_WINDOW, win);
            write_reg(CFG_SPAN, sp);

            // every chain entry must hold a point before it is scanned
            for (int k = 0; k < len; k++)
                if (!written[k])
                    push_item(make_load(k), 1'b0, '0);

            hi_load = (len + 31 > MAX_POINTS - 1) ? MAX_POINTS - 1 : len + 31;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 25) begin
                    if ($urandom_range(0, 9) == 0)
                        pos = $urandom_range(0, MAX_POINTS - 1);
                    else
                        pos = $urandom_range(0, hi_load);
                    push_item(make_load(pos), 1'b0, '0);
                end else begin
                    if (len > 0 && $urandom_range(0, 4) != 0)
                        pos = $urandom_range(0, len - 1);
                    else
                        pos = written_list[$urandom_range(0, written_list.size() - 1)];
                    push_item(make_query(pos), 1'b0, '0);
                end
                if ($urandom_range(0, 24) == 0)
                    quiesce();
            end
        end

        quiesce();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_windowed_nearest_neighbor_search_core: PASS");
        else
            $display("tb_windowed_nearest_neighbor_search_core: FAIL");
        $finish;
    end

endmodule

[windowed_nearest_neighbor_search_core.f]
rtl/wnns_pkg.sv
rtl/wnns_store.sv
rtl/wnns_dist.sv
rtl/wnns_ctrl.sv
rtl/windowed_nearest_neighbor_search_core.sv
tb/tb_windowed_nearest_neighbor_search_core.sv
